// ===== rtl/core/bclcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bclcd_pkg
// Shared types and constants for the button click / long press / combo
// detector: field widths, reset values, register indexes, event codes and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bclcd_pkg;

  // Sizes
  localparam int NUM_BUTTONS = 4;
  localparam int BTN_W       = 2;
  localparam int ACT_W       = 3;
  localparam int TIME_W      = 32;
  localparam int CLICK_W     = 8;
  localparam int KIND_W      = 3;
  localparam int EN_W        = 3 * NUM_BUTTONS;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_GAP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COMBO_HOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLES    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTONS    = 3'd5;

  // Register reset values
  localparam logic [TIME_W-1:0] DEBOUNCE_RST   = 32'd30000;
  localparam logic [TIME_W-1:0] LONG_PRESS_RST = 32'd700000;
  localparam logic [TIME_W-1:0] CLICK_GAP_RST  = 32'd250000;
  localparam logic [TIME_W-1:0] COMBO_HOLD_RST = 32'd800000;
  localparam logic [EN_W-1:0]   ENABLES_RST    = '1;
  localparam logic [ACT_W-1:0]  BUTTONS_RST    = 3'd4;

  // Click tally saturation
  localparam logic [CLICK_W-1:0] CLICK_MAX = 8'hFF;

  // Enable bit positions within one button's group
  localparam int EN_SINGLE = 0;
  localparam int EN_DOUBLE = 1;
  localparam int EN_MULTI  = 2;

  // Combo masks that map to a function
  localparam logic [NUM_BUTTONS-1:0] COMBO_RESET_MASK = 4'h3;
  localparam logic [NUM_BUTTONS-1:0] COMBO_SCENE_MASK = 4'hC;
  localparam logic ACTION_FACTORY_RESET = 1'b0;
  localparam logic ACTION_SCENE_CHANGE  = 1'b1;

  // Request type
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_SINGLE = 3'd0,
    KIND_DOUBLE = 3'd1,
    KIND_MULTI  = 3'd2,
    KIND_LONG   = 3'd3,
    KIND_COMBO  = 3'd4
  } kind_t;

  // Datapath operation for the current step
  typedef enum logic [2:0] {
    OP_NONE,
    OP_EDGE,
    OP_BTN,
    OP_COMBO,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    logic                   valid;
    kind_t                  kind;
    logic [BTN_W-1:0]       button;
    logic [CLICK_W-1:0]     clicks;
    logic [NUM_BUTTONS-1:0] mask;
    logic                   action;
  } result_t;

  typedef struct packed {
    logic             load;
    op_t              op;
    logic             go;
    logic [BTN_W-1:0] btn_sel;
  } cmd_t;

  typedef struct packed {
    logic             is_tick;
    logic [ACT_W-1:0] act_count;
    logic             cand_valid;
    logic             pend_valid;
    logic             out_free;
  } status_t;

endpackage

// ===== rtl/core/bclcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// bclcd_ctrl
// Sequencer: accepts one transaction, dispatches it as an edge step or a
// sweep over the active buttons plus a combo step, then flushes the last
// pending result. Stalls a step while the output side cannot take a result.
// ----------------------------------------------------------------------------
module bclcd_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bclcd_pkg::status_t         status,
  output bclcd_pkg::cmd_t            cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_EDGE,
    ST_BTN,
    ST_COMBO,
    ST_FLUSH
  } state_t;

  state_t                        state_r;
  logic [bclcd_pkg::BTN_W-1:0]   cnt_r;
  logic                          step_ok;
  logic                          flush_ok;
  logic                          last_btn;

  // Step may commit unless it would displace a pending result into a busy output
  assign step_ok  = !(status.cand_valid && status.pend_valid && !status.out_free);
  assign flush_ok = !status.pend_valid || status.out_free;
  assign last_btn = (bclcd_pkg::ACT_W'(cnt_r) + bclcd_pkg::ACT_W'(1)) == status.act_count;

  assign in_ready = (state_r == ST_IDLE);

  // Decode commands from state
  always_comb begin
    cmd.load    = (state_r == ST_IDLE) && in_valid;
    cmd.btn_sel = cnt_r;
    cmd.op      = bclcd_pkg::OP_NONE;
    cmd.go      = 1'b0;
    unique case (state_r)
      ST_EDGE: begin
        cmd.op = bclcd_pkg::OP_EDGE;
        cmd.go = step_ok;
      end
      ST_BTN: begin
        cmd.op = bclcd_pkg::OP_BTN;
        cmd.go = step_ok;
      end
      ST_COMBO: begin
        cmd.op = bclcd_pkg::OP_COMBO;
        cmd.go = step_ok;
      end
      ST_FLUSH: begin
        cmd.op = bclcd_pkg::OP_FLUSH;
        cmd.go = flush_ok;
      end
      default: begin
        cmd.op = bclcd_pkg::OP_NONE;
        cmd.go = 1'b0;
      end
    endcase
  end

  // Hold state and button counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          cnt_r <= '0;
          if (!status.is_tick) begin
            state_r <= ST_EDGE;
          end else if (status.act_count == '0) begin
            state_r <= ST_COMBO;
          end else begin
            state_r <= ST_BTN;
          end
        end
        ST_EDGE: begin
          if (step_ok) begin
            state_r <= ST_FLUSH;
          end
        end
        ST_BTN: begin
          if (step_ok) begin
            if (last_btn) begin
              state_r <= ST_COMBO;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        ST_COMBO: begin
          if (step_ok) begin
            state_r <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (flush_ok) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/bclcd_datapath.sv =====
// ----------------------------------------------------------------------------
// bclcd_datapath
// Configuration registers, per-button debounce/click/press state, the
// combo accumulator, and a pending-result stage in front of the output
// register that marks the last result of each transaction.
// ----------------------------------------------------------------------------
module bclcd_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [bclcd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bclcd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                  in_req_type,
  input  logic [bclcd_pkg::BTN_W-1:0]           in_button_index,
  input  logic                                  in_pin_level,
  input  logic [bclcd_pkg::TIME_W-1:0]          in_time_now,
  input  bclcd_pkg::cmd_t                       cmd,
  output bclcd_pkg::status_t                    status,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [bclcd_pkg::KIND_W-1:0]          out_event_kind,
  output logic [bclcd_pkg::BTN_W-1:0]           out_event_button,
  output logic [bclcd_pkg::CLICK_W-1:0]         out_clicks,
  output logic [bclcd_pkg::NUM_BUTTONS-1:0]     out_combo_buttons,
  output logic                                  out_combo_action,
  output logic                                  out_last_of_run
);

  localparam int NB = bclcd_pkg::NUM_BUTTONS;
  localparam int TW = bclcd_pkg::TIME_W;
  localparam int CW = bclcd_pkg::CLICK_W;

  // Configuration
  logic [TW-1:0]                  debounce_r;
  logic [TW-1:0]                  long_press_r;
  logic [TW-1:0]                  click_gap_r;
  logic [TW-1:0]                  combo_hold_r;
  logic [bclcd_pkg::EN_W-1:0]     enables_r;
  logic [bclcd_pkg::ACT_W-1:0]    buttons_r;

  // Latched transaction
  logic                           type_r;
  logic [bclcd_pkg::BTN_W-1:0]    idx_r;
  logic                           level_r;
  logic [TW-1:0]                  now_r;

  // Per-button state
  logic [NB-1:0]                  settled_r, settled_nxt;
  logic [NB-1:0]                  held_r, held_nxt;
  logic [NB-1:0]                  long_done_r, long_done_nxt;
  logic [TW-1:0]                  last_edge_r [NB];
  logic [TW-1:0]                  last_edge_nxt [NB];
  logic [TW-1:0]                  press_r [NB];
  logic [TW-1:0]                  press_nxt [NB];
  logic [TW-1:0]                  release_r [NB];
  logic [TW-1:0]                  release_nxt [NB];
  logic [CW-1:0]                  tally_r [NB];
  logic [CW-1:0]                  tally_nxt [NB];
  logic                           combo_done_r, combo_done_nxt;

  // Combo accumulator over the button sweep
  logic [NB-1:0]                  mask_r;
  logic [TW-1:0]                  oldest_r;

  // Result staging
  bclcd_pkg::result_t             cand;
  bclcd_pkg::result_t             pend_r;
  logic                           pend_valid_r;
  bclcd_pkg::result_t             out_res_r;
  logic                           out_valid_r;
  logic                           out_last_r;
  logic                           push_out;
  logic                           push_last;

  // Step decode
  logic [bclcd_pkg::BTN_W-1:0]    sel;
  logic [bclcd_pkg::ACT_W-1:0]    act_count;
  logic [NB-1:0]                  act_mask;
  logic [NB-1:0]                  sel_onehot;
  logic [2:0]                     en_arr [NB];
  logic [2:0]                     ev;
  logic [TW-1:0]                  age_edge, age_press, age_rel;
  logic                           e_pass, e_change, e_press, e_rel, e_emit;
  logic                           direct;
  logic                           other_held;
  logic                           b_long, b_click;
  logic                           c_fire;

  // Active button count, saturated at the number of buttons
  assign act_count = (buttons_r > bclcd_pkg::ACT_W'(NB)) ? bclcd_pkg::ACT_W'(NB) : buttons_r;

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      act_mask[i] = bclcd_pkg::ACT_W'(i) < act_count;
      en_arr[i]   = enables_r[3*i +: 3];
    end
  end

  assign sel        = (cmd.op == bclcd_pkg::OP_EDGE) ? idx_r : cmd.btn_sel;
  assign sel_onehot = NB'(1) << sel;
  assign ev         = en_arr[sel];
  assign direct     = ev[bclcd_pkg::EN_SINGLE] && !ev[bclcd_pkg::EN_DOUBLE];

  // Wrapped ages of the selected button
  assign age_edge  = now_r - last_edge_r[sel];
  assign age_press = now_r - press_r[sel];
  assign age_rel   = now_r - release_r[sel];

  // Edge step conditions
  assign e_pass     = ({1'b0, idx_r} < act_count) && !(age_edge < debounce_r);
  assign e_change   = e_pass && (level_r != settled_r[sel]);
  assign e_press    = e_change && !level_r;
  assign e_rel      = e_change && level_r;
  assign e_emit     = e_rel && !long_done_r[sel] && direct;
  assign other_held = |(held_r & act_mask & ~sel_onehot);

  // Button sweep conditions
  assign b_long  = held_r[sel] && !long_done_r[sel] && !(age_press < long_press_r);
  assign b_click = !held_r[sel] && (tally_r[sel] != '0) && !(age_rel < click_gap_r);

  // Combo step condition
  assign c_fire = !combo_done_r && ($countones(mask_r) >= 2) && !(oldest_r < combo_hold_r);

  // Build the result this step would produce
  always_comb begin
    cand        = '0;
    cand.kind   = bclcd_pkg::KIND_SINGLE;
    unique case (cmd.op)
      bclcd_pkg::OP_EDGE: begin
        if (e_emit) begin
          cand.valid  = 1'b1;
          cand.kind   = bclcd_pkg::KIND_SINGLE;
          cand.button = sel;
          cand.clicks = CW'(1);
        end
      end
      bclcd_pkg::OP_BTN: begin
        cand.button = sel;
        if (b_long) begin
          cand.valid = 1'b1;
          cand.kind  = bclcd_pkg::KIND_LONG;
        end else if (b_click) begin
          if (tally_r[sel] == CW'(1)) begin
            cand.valid  = ev[bclcd_pkg::EN_SINGLE];
            cand.kind   = bclcd_pkg::KIND_SINGLE;
            cand.clicks = CW'(1);
          end else if (tally_r[sel] == CW'(2)) begin
            cand.valid  = ev[bclcd_pkg::EN_DOUBLE] || ev[bclcd_pkg::EN_MULTI];
            cand.kind   = ev[bclcd_pkg::EN_DOUBLE] ? bclcd_pkg::KIND_DOUBLE
                                                   : bclcd_pkg::KIND_MULTI;
            cand.clicks = CW'(2);
          end else begin
            cand.valid  = ev[bclcd_pkg::EN_MULTI];
            cand.kind   = bclcd_pkg::KIND_MULTI;
            cand.clicks = tally_r[sel];
          end
        end
      end
      bclcd_pkg::OP_COMBO: begin
        if (c_fire && mask_r == bclcd_pkg::COMBO_RESET_MASK) begin
          cand.valid  = 1'b1;
          cand.kind   = bclcd_pkg::KIND_COMBO;
          cand.mask   = mask_r;
          cand.action = bclcd_pkg::ACTION_FACTORY_RESET;
        end else if (c_fire && mask_r == bclcd_pkg::COMBO_SCENE_MASK) begin
          cand.valid  = 1'b1;
          cand.kind   = bclcd_pkg::KIND_COMBO;
          cand.mask   = mask_r;
          cand.action = bclcd_pkg::ACTION_SCENE_CHANGE;
        end
      end
      default: ;
    endcase
  end

  // Next per-button state
  always_comb begin
    settled_nxt    = settled_r;
    held_nxt       = held_r;
    long_done_nxt  = long_done_r;
    last_edge_nxt  = last_edge_r;
    press_nxt      = press_r;
    release_nxt    = release_r;
    tally_nxt      = tally_r;
    combo_done_nxt = combo_done_r;
    if (cmd.go) begin
      unique case (cmd.op)
        bclcd_pkg::OP_EDGE: begin
          if (e_pass) begin
            last_edge_nxt[sel] = now_r;
          end
          if (e_press) begin
            settled_nxt[sel]   = 1'b0;
            held_nxt[sel]      = 1'b1;
            long_done_nxt[sel] = 1'b0;
            press_nxt[sel]     = now_r;
            combo_done_nxt     = 1'b0;
          end
          if (e_rel) begin
            settled_nxt[sel] = 1'b1;
            held_nxt[sel]    = 1'b0;
            release_nxt[sel] = now_r;
            if (!long_done_r[sel]) begin
              if (direct) begin
                tally_nxt[sel] = '0;
              end else if (tally_r[sel] != bclcd_pkg::CLICK_MAX) begin
                tally_nxt[sel] = tally_r[sel] + 1'b1;
              end
            end
            if (!other_held) begin
              combo_done_nxt = 1'b0;
            end
          end
        end
        bclcd_pkg::OP_BTN: begin
          if (b_long) begin
            long_done_nxt[sel] = 1'b1;
            tally_nxt[sel]     = '0;
          end else if (b_click) begin
            tally_nxt[sel] = '0;
          end
        end
        bclcd_pkg::OP_COMBO: begin
          if (c_fire) begin
            combo_done_nxt = 1'b1;
            for (int i = 0; i < NB; i++) begin
              if (mask_r[i]) begin
                long_done_nxt[i] = 1'b1;
                tally_nxt[i]     = '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= bclcd_pkg::DEBOUNCE_RST;
      long_press_r <= bclcd_pkg::LONG_PRESS_RST;
      click_gap_r  <= bclcd_pkg::CLICK_GAP_RST;
      combo_hold_r <= bclcd_pkg::COMBO_HOLD_RST;
      enables_r    <= bclcd_pkg::ENABLES_RST;
      buttons_r    <= bclcd_pkg::BUTTONS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bclcd_pkg::CFG_DEBOUNCE:   debounce_r   <= cfg_wdata[TW-1:0];
        bclcd_pkg::CFG_LONG_PRESS: long_press_r <= cfg_wdata[TW-1:0];
        bclcd_pkg::CFG_CLICK_GAP:  click_gap_r  <= cfg_wdata[TW-1:0];
        bclcd_pkg::CFG_COMBO_HOLD: combo_hold_r <= cfg_wdata[TW-1:0];
        bclcd_pkg::CFG_ENABLES:    enables_r    <= cfg_wdata[bclcd_pkg::EN_W-1:0];
        bclcd_pkg::CFG_BUTTONS:    buttons_r    <= cfg_wdata[bclcd_pkg::ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r  <= in_req_type;
      idx_r   <= in_button_index;
      level_r <= in_pin_level;
      now_r   <= in_time_now;
    end
  end

  // Per-button state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settled_r    <= '1;
      held_r       <= '0;
      long_done_r  <= '0;
      combo_done_r <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        last_edge_r[i] <= '0;
        press_r[i]     <= '0;
        release_r[i]   <= '0;
        tally_r[i]     <= '0;
      end
    end else begin
      settled_r    <= settled_nxt;
      held_r       <= held_nxt;
      long_done_r  <= long_done_nxt;
      combo_done_r <= combo_done_nxt;
      last_edge_r  <= last_edge_nxt;
      press_r      <= press_nxt;
      release_r    <= release_nxt;
      tally_r      <= tally_nxt;
    end
  end

  // Accumulate held mask and oldest press age during the sweep
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mask_r   <= '0;
      oldest_r <= '0;
    end else if (cmd.go && cmd.op == bclcd_pkg::OP_BTN && held_r[sel]) begin
      mask_r[sel] <= 1'b1;
      if (age_press > oldest_r) begin
        oldest_r <= age_press;
      end
    end
  end

  // Hand the pending result on when a new one displaces it or at the flush
  always_comb begin
    push_out  = 1'b0;
    push_last = 1'b0;
    if (cmd.go && pend_valid_r) begin
      unique case (cmd.op)
        bclcd_pkg::OP_EDGE, bclcd_pkg::OP_BTN, bclcd_pkg::OP_COMBO: begin
          push_out = cand.valid;
        end
        bclcd_pkg::OP_FLUSH: begin
          push_out  = 1'b1;
          push_last = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Pending result and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (push_out) begin
        out_valid_r <= 1'b1;
        out_res_r   <= pend_r;
        out_last_r  <= push_last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.go) begin
        unique case (cmd.op)
          bclcd_pkg::OP_EDGE, bclcd_pkg::OP_BTN, bclcd_pkg::OP_COMBO: begin
            if (cand.valid) begin
              pend_r       <= cand;
              pend_valid_r <= 1'b1;
            end
          end
          bclcd_pkg::OP_FLUSH: begin
            pend_valid_r <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Status to the controller
  assign status.is_tick    = (type_r == bclcd_pkg::REQ_TICK);
  assign status.act_count  = act_count;
  assign status.cand_valid = cand.valid;
  assign status.pend_valid = pend_valid_r;
  assign status.out_free   = !out_valid_r || out_ready;

  // Drive the result channel
  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_res_r.kind;
  assign out_event_button  = out_res_r.button;
  assign out_clicks        = out_res_r.clicks;
  assign out_combo_buttons = out_res_r.mask;
  assign out_combo_action  = out_res_r.action;
  assign out_last_of_run   = out_last_r;

endmodule

// ===== rtl/core/button_click_long_combo_detector.sv =====
// ----------------------------------------------------------------------------
// button_click_long_combo_detector
// Debounces button edges and, on time ticks, reports click counts, long
// presses and two-button combo long presses for up to four buttons.
//
//   Channel  Direction  Handshake        Payload
//   in_      input      valid / ready    req_type, button_index, pin_level, time_now
//   out_     output     valid / ready    event_kind, event_button, clicks,
//                                        combo_buttons, combo_action, last_of_run
//   cfg_     input      write enable     index, wdata (32 bits)
//
// An edge transaction runs accept, dispatch, edge step and flush in order.
// A tick runs accept and dispatch, then one sweep step per active button
// through the shared age comparators, then a combo step, then a flush.
// Each result waits in a pending stage so the last one can be flagged; a step
// that has a result to hand on stalls while the output register is full.
// Reset (synchronous, active low) restores register defaults and resets all
// button state.
// ----------------------------------------------------------------------------
module button_click_long_combo_detector (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [bclcd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bclcd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_req_type,
  input  logic [bclcd_pkg::BTN_W-1:0]           in_button_index,
  input  logic                                  in_pin_level,
  input  logic [bclcd_pkg::TIME_W-1:0]          in_time_now,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bclcd_pkg::KIND_W-1:0]          out_event_kind,
  output logic [bclcd_pkg::BTN_W-1:0]           out_event_button,
  output logic [bclcd_pkg::CLICK_W-1:0]         out_clicks,
  output logic [bclcd_pkg::NUM_BUTTONS-1:0]     out_combo_buttons,
  output logic                                  out_combo_action,
  output logic                                  out_last_of_run
);

  bclcd_pkg::cmd_t    cmd;
  bclcd_pkg::status_t status;

  // Sequencer
  bclcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // State, comparators and result staging
  bclcd_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_req_type       (in_req_type),
    .in_button_index   (in_button_index),
    .in_pin_level      (in_pin_level),
    .in_time_now       (in_time_now),
    .cmd               (cmd),
    .status            (status),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_event_kind    (out_event_kind),
    .out_event_button  (out_event_button),
    .out_clicks        (out_clicks),
    .out_combo_buttons (out_combo_buttons),
    .out_combo_action  (out_combo_action),
    .out_last_of_run   (out_last_of_run)
  );

endmodule
